[hw/rtl/afpd_pkg.sv]
package afpd_pkg;

    localparam int WORD_W  = 32;
    localparam int CODE_W  = 8;
    localparam int CLASS_W = 4;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [CLASS_W-1:0] class_t;

    localparam class_t CLS_FIXED   = 4'd0;
    localparam class_t CLS_INT     = 4'd1;
    localparam class_t CLS_ONE_SRC = 4'd2;
    localparam class_t CLS_CMP     = 4'd3;
    localparam class_t CLS_IMM     = 4'd4;
    localparam class_t CLS_CCMP    = 4'd5;
    localparam class_t CLS_TWO_SRC = 4'd6;
    localparam class_t CLS_CSEL    = 4'd7;
    localparam class_t CLS_THREE   = 4'd8;
    localparam class_t CLS_UNALLOC = 4'd9;

    localparam code_t CODE_INVALID = 8'd0;

    typedef struct packed {
        code_t  code;
        class_t cls;
    } result_t;

endpackage

[hw/rtl/afpd_decode.sv]
module afpd_decode (
    input  afpd_pkg::word_t   word,
    output afpd_pkg::result_t result
);
    import afpd_pkg::*;

    function automatic code_t dec_fixed(input word_t w);
        logic [1:0] idx;
        logic       ok;
        begin
            ok  = 1'b1;
            idx = 2'd0;
            if (w[20:19] == 2'd0 && w[18:16] == 3'd2) idx = 2'd0;
            else if (w[20:19] == 2'd0 && w[18:16] == 3'd3) idx = 2'd1;
            else if (w[20:19] == 2'd3 && w[18:16] == 3'd0) idx = 2'd2;
            else if (w[20:19] == 2'd3 && w[18:16] == 3'd1) idx = 2'd3;
            else ok = 1'b0;
            if (w[29] || w[23] || !ok) dec_fixed = CODE_INVALID;
            else dec_fixed = 8'd1 + {4'd0, w[31], w[22], idx};
        end
    endfunction

    function automatic code_t dec_int(input word_t w);
        code_t      base;
        code_t      first;
        logic       has_fmov;
        logic [1:0] rm1;
        begin
            base     = w[31] ? (w[22] ? 8'd55 : 8'd43) : (w[22] ? 8'd31 : 8'd17);
            has_fmov = (w[31] == w[22]);
            first    = has_fmov ? 8'd8 : 8'd6;
            rm1      = w[20:19] - 2'd1;
            if (w[29]) dec_int = CODE_INVALID;
            else if (w[23:22] == 2'd2)
            begin
                if (w[31] && w[20:19] == 2'd1 && w[18:16] == 3'd6) dec_int = 8'd69;
                else if (w[31] && w[20:19] == 2'd1 && w[18:16] == 3'd7) dec_int = 8'd70;
                else dec_int = CODE_INVALID;
            end
            else if (w[23:22] == 2'd3) dec_int = CODE_INVALID;
            else if (w[20:19] == 2'd0)
            begin
                if (w[18:16] < 3'd6 || has_fmov) dec_int = base + {5'd0, w[18:16]};
                else dec_int = CODE_INVALID;
            end
            else if (w[18:16] > 3'd1) dec_int = CODE_INVALID;
            else dec_int = base + first + {5'd0, rm1, 1'b0} + {7'd0, w[16]};
        end
    endfunction

    function automatic code_t one_src_entry(input logic [4:0] sel);
        begin
            case (sel)
                5'd0:  one_src_entry = 8'd71;
                5'd1:  one_src_entry = 8'd72;
                5'd2:  one_src_entry = 8'd73;
                5'd3:  one_src_entry = 8'd74;
                5'd5:  one_src_entry = 8'd75;
                5'd7:  one_src_entry = 8'd76;
                5'd8:  one_src_entry = 8'd77;
                5'd9:  one_src_entry = 8'd78;
                5'd10: one_src_entry = 8'd79;
                5'd11: one_src_entry = 8'd80;
                5'd12: one_src_entry = 8'd81;
                5'd14: one_src_entry = 8'd82;
                5'd15: one_src_entry = 8'd83;
                5'd16: one_src_entry = 8'd84;
                5'd17: one_src_entry = 8'd85;
                5'd18: one_src_entry = 8'd86;
                5'd19: one_src_entry = 8'd87;
                5'd20: one_src_entry = 8'd88;
                5'd23: one_src_entry = 8'd89;
                5'd24: one_src_entry = 8'd90;
                5'd25: one_src_entry = 8'd91;
                5'd26: one_src_entry = 8'd92;
                5'd27: one_src_entry = 8'd93;
                5'd28: one_src_entry = 8'd94;
                5'd30: one_src_entry = 8'd95;
                5'd31: one_src_entry = 8'd96;
                default: one_src_entry = CODE_INVALID;
            endcase
        end
    endfunction

    function automatic code_t dec_one_src(input word_t w);
        begin
            if (w[31] || w[29] || w[23:22] == 2'd2 || w[20:19] != 2'd0)
                dec_one_src = CODE_INVALID;
            else if (w[23:22] == 2'd3)
            begin
                if (w[18:15] == 4'd4) dec_one_src = 8'd97;
                else if (w[18:15] == 4'd5) dec_one_src = 8'd98;
                else dec_one_src = CODE_INVALID;
            end
            else dec_one_src = one_src_entry({w[22], w[18:15]});
        end
    endfunction

    logic  bad_ms;
    code_t c_cmp;
    code_t c_imm;
    code_t c_ccmp;
    code_t c_two;
    code_t c_csel;
    code_t c_three;

    assign bad_ms = word[31] | word[29] | word[23];

    assign c_cmp = (bad_ms || word[15:14] != 2'd0 || word[2:0] != 3'd0) ? CODE_INVALID
                 : 8'd99 + {5'd0, word[22], word[4:3]};
    assign c_imm = (bad_ms || word[9:5] != 5'd0) ? CODE_INVALID
                 : 8'd107 + {7'd0, word[22]};
    assign c_ccmp = bad_ms ? CODE_INVALID : 8'd109 + {6'd0, word[22], word[4]};
    assign c_two = (bad_ms || word[15:12] > 4'd8) ? CODE_INVALID
                 : 8'd113 + (word[22] ? 8'd9 : 8'd0) + {4'd0, word[15:12]};
    assign c_csel = bad_ms ? CODE_INVALID : 8'd131 + {7'd0, word[22]};
    assign c_three = bad_ms ? CODE_INVALID
                   : 8'd133 + {5'd0, word[22], word[21], word[15]};

    always_comb
    begin
        if (word[24]) result = '{code: c_three, cls: CLS_THREE};
        else if (!word[21]) result = '{code: dec_fixed(word), cls: CLS_FIXED};
        else if (word[10])
        begin
            if (word[11]) result = '{code: c_csel, cls: CLS_CSEL};
            else result = '{code: c_ccmp, cls: CLS_CCMP};
        end
        else if (word[11]) result = '{code: c_two, cls: CLS_TWO_SRC};
        else if (word[12]) result = '{code: c_imm, cls: CLS_IMM};
        else if (word[13]) result = '{code: c_cmp, cls: CLS_CMP};
        else if (word[14]) result = '{code: dec_one_src(word), cls: CLS_ONE_SRC};
        else if (word[15]) result = '{code: CODE_INVALID, cls: CLS_UNALLOC};
        else result = '{code: dec_int(word), cls: CLS_INT};
    end

endmodule

[hw/rtl/aarch64_fp_instruction_decoder.sv]
// channel  signals                                          direction
// in       in_valid, in_stall, instr_word                   into block
// out      out_valid, out_stall, instr_code, instr_class    out of block
// path from accept to result: input register, decode logic, result register
// sustains one item per cycle while out_stall is low
// reset clears both valid registers; payload registers are not reset
// in_stall rises only when the input register holds an item and the result
// register is full and stalled
module aarch64_fp_instruction_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  afpd_pkg::word_t   instr_word,
    output logic              out_valid,
    input  logic              out_stall,
    output afpd_pkg::code_t   instr_code,
    output afpd_pkg::class_t  instr_class
);
    import afpd_pkg::*;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    word_t   word_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t res_reg;
    result_t res_next;
    logic    s2_en;
    logic    s1_en;

    afpd_decode u_decode (
        .word   (word_reg),
        .result (res_next)
    );

    assign s2_en = !(out_valid_reg && out_stall);
    assign s1_en = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;

    assign s1_valid_next  = s1_en ? in_valid : s1_valid_reg;
    assign out_valid_next = s2_en ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            word_reg <= instr_word;
        end
        if (s2_en && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign instr_code  = res_reg.code;
    assign instr_class = res_reg.cls;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted item lost before decode");

    a_unalloc_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && instr_class == CLS_UNALLOC) |-> (instr_code == CODE_INVALID))
        else $error("unallocated route gave a nonzero code");

    a_three_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && instr_class == CLS_THREE)
        |-> (instr_code == CODE_INVALID || (instr_code >= 8'd133 && instr_code <= 8'd140)))
        else $error("three-source code out of range");

endmodule
